// File: rtl/core/assert_macros.svh
// Assertion macros for the RGB to HSV converter checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RHC_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RHC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/rhc_pkg.sv
// Types and constants shared by the RGB to HSV converter modules.
`default_nettype none

package rhc_pkg;

  // Result field widths.
  localparam int HUE_W    = 9;
  localparam int SAT_W    = 7;
  localparam int BRIGHT_W = 9;
  localparam int CHAN_W   = 10;

  // Quotient bits produced by the divider pipeline; both quotients stay below 128.
  localparam int QUO_W = 7;

  // Hue scaling and sector offsets in degrees.
  localparam int HUE_SCALE     = 60;
  localparam int HUE_GREEN_OFS = 120;
  localparam int HUE_BLUE_OFS  = 240;
  localparam int HUE_WRAP      = 360;

  // Percent scale.
  localparam int PCT_SCALE = 100;

  // Brightness is floor(100 * max / 255), done as max * (100 * ceil(2^32 / 255)) >> 32.
  // The reciprocal error stays exact for products below 2^24, which covers 16-bit samples.
  localparam int BRIGHT_X_W   = 16;
  localparam int BRIGHT_M_W   = 31;
  localparam int BRIGHT_SHIFT = 32;
  localparam logic [BRIGHT_M_W-1:0] BRIGHT_MULT = 31'd1684301000;

  // Which channel holds the maximum, ties resolved red, then green, then blue.
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // Classification passed from the front end to the back end.
  typedef struct packed {
    sector_t sector;
    logic    neg;   // channel difference inside the sector is negative
    logic    grey;  // all channels equal
    logic    blk;   // maximum is zero
  } rhc_cls_t;

endpackage

`default_nettype wire

// File: rtl/core/rhc_if.sv
// Valid/ready channel interfaces for the converter's sample and result streams.
`default_nettype none

interface rhc_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] red;
  logic [SAMPLE_BITS-1:0] green;
  logic [SAMPLE_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_out_if;
  import rhc_pkg::*;

  logic                valid;
  logic                ready;
  logic [HUE_W-1:0]    hue;
  logic [SAT_W-1:0]    saturation;
  logic [BRIGHT_W-1:0] brightness;
  logic [CHAN_W-1:0]   channel_max;
  logic [CHAN_W-1:0]   channel_min;

  modport source (
    output valid, output hue, output saturation, output brightness,
    output channel_max, output channel_min, input ready
  );
  modport sink (
    input valid, input hue, input saturation, input brightness,
    input channel_max, input channel_min, output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/rgb_to_hsv_converter.sv
// Throughput: one sample per cycle while the result side is not stalled.
// The 7-stage divider pipeline resolves one quotient bit a stage.
// A 4-entry queue between the front end and the dividers absorbs stalls on the result side.
// Reset: synchronous, active low; clears valid flags and queue pointers, no data is cleared.
`default_nettype none

module rgb_to_hsv_converter #(
  parameter int SAMPLE_BITS = 10,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  rhc_in_if.sink    in_chan,
  rhc_out_if.source out_chan
);
  import rhc_pkg::*;

  localparam int NUM_W  = SAMPLE_BITS + QUO_W;
  localparam int CLS_W  = $bits(rhc_cls_t);
  localparam int WORD_W = CLS_W + 2 * NUM_W + 3 * SAMPLE_BITS;

  logic                   f_valid, f_ready;
  rhc_cls_t               f_cls, b_cls;
  logic [NUM_W-1:0]       f_num_h, f_num_s, b_num_h, b_num_s;
  logic [SAMPLE_BITS-1:0] f_diff, f_mx, f_mn, b_diff, b_mx, b_mn;
  logic                   b_valid, b_ready;
  logic [WORD_W-1:0]      q_in, q_out;

  // Front end: classify the sample.
  rhc_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .red      (in_chan.red),
    .green    (in_chan.green),
    .blue     (in_chan.blue),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .cls      (f_cls),
    .num_h    (f_num_h),
    .num_s    (f_num_s),
    .diff     (f_diff),
    .mx       (f_mx),
    .mn       (f_mn)
  );

  // Queue between front end and dividers.
  assign q_in = {f_cls, f_num_h, f_num_s, f_diff, f_mx, f_mn};

  rhc_queue #(
    .DATA_W(WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_data  (q_in),
    .out_valid(b_valid),
    .out_ready(b_ready),
    .out_data (q_out)
  );

  assign {b_cls, b_num_h, b_num_s, b_diff, b_mx, b_mn} = q_out;

  // Back end: dividers and result assembly.
  rhc_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (b_valid),
    .in_ready   (b_ready),
    .cls        (b_cls),
    .num_h      (b_num_h),
    .num_s      (b_num_s),
    .diff       (b_diff),
    .mx         (b_mx),
    .mn         (b_mn),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .hue        (out_chan.hue),
    .saturation (out_chan.saturation),
    .brightness (out_chan.brightness),
    .channel_max(out_chan.channel_max),
    .channel_min(out_chan.channel_min)
  );

endmodule

`default_nettype wire

// File: rtl/core/rhc_front.sv
// Front end: accepts a sample, finds max, min and sector, and forms divider operands.
`default_nettype none

module rhc_front #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [SAMPLE_BITS-1:0]                   red,
  input  logic [SAMPLE_BITS-1:0]                   green,
  input  logic [SAMPLE_BITS-1:0]                   blue,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output rhc_pkg::rhc_cls_t                        cls,
  output logic [SAMPLE_BITS+rhc_pkg::QUO_W-1:0]    num_h,
  output logic [SAMPLE_BITS+rhc_pkg::QUO_W-1:0]    num_s,
  output logic [SAMPLE_BITS-1:0]                   diff,
  output logic [SAMPLE_BITS-1:0]                   mx,
  output logic [SAMPLE_BITS-1:0]                   mn
);
  import rhc_pkg::*;

  localparam int NUM_W = SAMPLE_BITS + QUO_W;

  logic                   fv_r;
  rhc_cls_t               cls_r, cls_nxt;
  logic [NUM_W-1:0]       num_h_r, num_h_nxt;
  logic [NUM_W-1:0]       num_s_r, num_s_nxt;
  logic [SAMPLE_BITS-1:0] diff_r, diff_nxt;
  logic [SAMPLE_BITS-1:0] mx_r, mx_nxt;
  logic [SAMPLE_BITS-1:0] mn_r, mn_nxt;
  logic [SAMPLE_BITS-1:0] op_a, op_c, mag;

  // The front register takes a new request whenever it is empty or drains into the queue.
  assign in_ready = !fv_r || out_ready;

  // Classify the sample and build numerators for hue and saturation.
  always_comb begin
    mx_nxt = red;
    if (mx_nxt < green) mx_nxt = green;
    if (mx_nxt < blue) mx_nxt = blue;
    mn_nxt = red;
    if (mn_nxt > green) mn_nxt = green;
    if (mn_nxt > blue) mn_nxt = blue;
    diff_nxt = mx_nxt - mn_nxt;

    if (mx_nxt == red) begin
      cls_nxt.sector = SECT_RED;
      op_a = green;
      op_c = blue;
    end else if (mx_nxt == green) begin
      cls_nxt.sector = SECT_GREEN;
      op_a = blue;
      op_c = red;
    end else begin
      cls_nxt.sector = SECT_BLUE;
      op_a = red;
      op_c = green;
    end
    cls_nxt.neg  = op_a < op_c;
    cls_nxt.grey = diff_nxt == '0;
    cls_nxt.blk  = mx_nxt == '0;
    mag = cls_nxt.neg ? (op_c - op_a) : (op_a - op_c);

    num_h_nxt = NUM_W'(mag) * NUM_W'(HUE_SCALE);
    num_s_nxt = NUM_W'(diff_nxt) * NUM_W'(PCT_SCALE);
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ready) begin
      fv_r <= in_valid;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cls_r   <= cls_nxt;
      num_h_r <= num_h_nxt;
      num_s_r <= num_s_nxt;
      diff_r  <= diff_nxt;
      mx_r    <= mx_nxt;
      mn_r    <= mn_nxt;
    end
  end

  assign out_valid = fv_r;
  assign cls       = cls_r;
  assign num_h     = num_h_r;
  assign num_s     = num_s_r;
  assign diff      = diff_r;
  assign mx        = mx_r;
  assign mn        = mn_r;

endmodule

`default_nettype wire

// File: rtl/core/rhc_queue.sv
// Small FIFO that decouples the front end from the divider pipeline.
`default_nettype none

module rhc_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              push, pop;

  assign in_ready  = cnt_r != CNT_W'(DEPTH);
  assign out_valid = cnt_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointer and count updates; pointers wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rhc_back.sv
// Back end: pipelined restoring dividers, brightness scaling and result assembly.
`default_nettype none

module rhc_back #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  rhc_pkg::rhc_cls_t                     cls,
  input  logic [SAMPLE_BITS+rhc_pkg::QUO_W-1:0] num_h,
  input  logic [SAMPLE_BITS+rhc_pkg::QUO_W-1:0] num_s,
  input  logic [SAMPLE_BITS-1:0]                diff,
  input  logic [SAMPLE_BITS-1:0]                mx,
  input  logic [SAMPLE_BITS-1:0]                mn,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [rhc_pkg::HUE_W-1:0]             hue,
  output logic [rhc_pkg::SAT_W-1:0]             saturation,
  output logic [rhc_pkg::BRIGHT_W-1:0]          brightness,
  output logic [rhc_pkg::CHAN_W-1:0]            channel_max,
  output logic [rhc_pkg::CHAN_W-1:0]            channel_min
);
  import rhc_pkg::*;

  localparam int NUM_W  = SAMPLE_BITS + QUO_W;
  localparam int LAST   = QUO_W - 1;
  localparam int PROD_W = BRIGHT_X_W + BRIGHT_M_W;
  localparam int CALC_W = HUE_W + 1;

  // One register set per quotient bit.
  logic [QUO_W-1:0]       v_r;
  logic [NUM_W-1:0]       rem_h_r [QUO_W];
  logic [NUM_W-1:0]       rem_h_nxt [QUO_W];
  logic [NUM_W-1:0]       rem_s_r [QUO_W];
  logic [NUM_W-1:0]       rem_s_nxt [QUO_W];
  logic [QUO_W-1:0]       q_h_r [QUO_W];
  logic [QUO_W-1:0]       q_h_nxt [QUO_W];
  logic [QUO_W-1:0]       q_s_r [QUO_W];
  logic [QUO_W-1:0]       q_s_nxt [QUO_W];
  logic [SAMPLE_BITS-1:0] den_r [QUO_W];
  logic [SAMPLE_BITS-1:0] den_nxt [QUO_W];
  logic [SAMPLE_BITS-1:0] mx_r [QUO_W];
  logic [SAMPLE_BITS-1:0] mx_nxt [QUO_W];
  logic [SAMPLE_BITS-1:0] mn_r [QUO_W];
  logic [SAMPLE_BITS-1:0] mn_nxt [QUO_W];
  rhc_cls_t               cls_r [QUO_W];
  rhc_cls_t               cls_nxt [QUO_W];
  logic [BRIGHT_W-1:0]    bright_r [QUO_W-1];
  logic [BRIGHT_W-1:0]    bright_nxt [QUO_W-1];
  logic [PROD_W-1:0]      prod_r, prod_nxt;

  // Output register.
  logic                out_valid_r;
  logic [HUE_W-1:0]    hue_r, hue_nxt;
  logic [SAT_W-1:0]    sat_r, sat_nxt;
  logic [BRIGHT_W-1:0] bright_out_r;
  logic [CHAN_W-1:0]   chmax_r, chmin_r;

  logic                   adv;
  logic [NUM_W-1:0]       src_rem_h, src_rem_s, trial_h, trial_s;
  logic [QUO_W-1:0]       src_q_h, src_q_s, qbit;
  logic [SAMPLE_BITS-1:0] src_den, src_mx;
  logic [CALC_W-1:0]      qx, hue_calc;
  logic                   rem_nz;
  logic [BRIGHT_X_W-1:0]  mx_ext;

  // The whole pipeline moves unless a finished result is still waiting.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // One restoring step per stage: stage k resolves quotient bit LAST-k.
  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      if (k == 0) begin
        src_rem_h  = num_h;
        src_rem_s  = num_s;
        src_q_h    = '0;
        src_q_s    = '0;
        src_den    = diff;
        src_mx     = mx;
        mn_nxt[k]  = mn;
        cls_nxt[k] = cls;
      end else begin
        src_rem_h  = rem_h_r[k-1];
        src_rem_s  = rem_s_r[k-1];
        src_q_h    = q_h_r[k-1];
        src_q_s    = q_s_r[k-1];
        src_den    = den_r[k-1];
        src_mx     = mx_r[k-1];
        mn_nxt[k]  = mn_r[k-1];
        cls_nxt[k] = cls_r[k-1];
      end
      den_nxt[k] = src_den;
      mx_nxt[k]  = src_mx;
      qbit       = QUO_W'(1) << (LAST - k);
      trial_h    = NUM_W'(src_den) << (LAST - k);
      trial_s    = NUM_W'(src_mx) << (LAST - k);
      if (src_rem_h >= trial_h) begin
        rem_h_nxt[k] = src_rem_h - trial_h;
        q_h_nxt[k]   = src_q_h | qbit;
      end else begin
        rem_h_nxt[k] = src_rem_h;
        q_h_nxt[k]   = src_q_h;
      end
      if (src_rem_s >= trial_s) begin
        rem_s_nxt[k] = src_rem_s - trial_s;
        q_s_nxt[k]   = src_q_s | qbit;
      end else begin
        rem_s_nxt[k] = src_rem_s;
        q_s_nxt[k]   = src_q_s;
      end
    end
  end

  // Brightness: multiply in the first stage, take the scaled bits in the second.
  always_comb begin
    mx_ext   = BRIGHT_X_W'(mx);
    prod_nxt = PROD_W'(mx_ext) * PROD_W'(BRIGHT_MULT);
    for (int k = 0; k < QUO_W - 1; k++) begin
      if (k == 0) begin
        bright_nxt[k] = prod_r[BRIGHT_SHIFT +: BRIGHT_W];
      end else begin
        bright_nxt[k] = bright_r[k-1];
      end
    end
  end

  // Hue from sector, sign, quotient and whether the division was exact.
  always_comb begin
    qx       = CALC_W'(q_h_r[LAST]);
    rem_nz   = rem_h_r[LAST] != '0;
    hue_calc = '0;
    case (cls_r[LAST].sector)
      SECT_RED: begin
        if (!cls_r[LAST].neg) begin
          hue_calc = qx;
        end else if (qx != '0) begin
          hue_calc = CALC_W'(HUE_WRAP) - qx;
        end
      end
      SECT_GREEN: begin
        if (cls_r[LAST].neg) begin
          hue_calc = CALC_W'(HUE_GREEN_OFS) - qx - CALC_W'(rem_nz);
        end else begin
          hue_calc = CALC_W'(HUE_GREEN_OFS) + qx;
        end
      end
      SECT_BLUE: begin
        if (cls_r[LAST].neg) begin
          hue_calc = CALC_W'(HUE_BLUE_OFS) - qx - CALC_W'(rem_nz);
        end else begin
          hue_calc = CALC_W'(HUE_BLUE_OFS) + qx;
        end
      end
      default: begin
        hue_calc = '0;
      end
    endcase
    hue_nxt = cls_r[LAST].grey ? '0 : hue_calc[HUE_W-1:0];
    sat_nxt = cls_r[LAST].blk ? '0 : SAT_W'(q_s_r[LAST]);
  end

  // Stage and output valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[LAST-1:0], in_valid};
      out_valid_r <= v_r[LAST];
    end
  end

  // Stage and output payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < QUO_W; k++) begin
        rem_h_r[k] <= rem_h_nxt[k];
        rem_s_r[k] <= rem_s_nxt[k];
        q_h_r[k]   <= q_h_nxt[k];
        q_s_r[k]   <= q_s_nxt[k];
        den_r[k]   <= den_nxt[k];
        mx_r[k]    <= mx_nxt[k];
        mn_r[k]    <= mn_nxt[k];
        cls_r[k]   <= cls_nxt[k];
      end
      for (int k = 0; k < QUO_W - 1; k++) begin
        bright_r[k] <= bright_nxt[k];
      end
      prod_r       <= prod_nxt;
      hue_r        <= hue_nxt;
      sat_r        <= sat_nxt;
      bright_out_r <= bright_r[QUO_W-2];
      chmax_r      <= CHAN_W'(mx_r[LAST]);
      chmin_r      <= CHAN_W'(mn_r[LAST]);
    end
  end

  assign out_valid   = out_valid_r;
  assign hue         = hue_r;
  assign saturation  = sat_r;
  assign brightness  = bright_out_r;
  assign channel_max = chmax_r;
  assign channel_min = chmin_r;

endmodule

`default_nettype wire

// File: rtl/core/rhc_checker.sv
// Port-level assertions for the RGB to HSV converter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module rhc_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [rhc_pkg::HUE_W-1:0]    hue,
  input wire logic [rhc_pkg::SAT_W-1:0]    saturation,
  input wire logic [rhc_pkg::BRIGHT_W-1:0] brightness,
  input wire logic [rhc_pkg::CHAN_W-1:0]   channel_max,
  input wire logic [rhc_pkg::CHAN_W-1:0]   channel_min
);
  import rhc_pkg::*;

  localparam int RES_W = HUE_W + SAT_W + BRIGHT_W + 2 * CHAN_W;
  localparam logic [HUE_W-1:0] HUE_LIM = HUE_W'(HUE_WRAP);
  localparam logic [SAT_W-1:0] SAT_MAX = SAT_W'(PCT_SCALE);

  logic             stalled;
  logic [RES_W-1:0] res_word;

  // A result is stalled when it is offered and not taken.
  assign stalled  = out_valid && !out_ready;
  assign res_word = {hue, saturation, brightness, channel_max, channel_min};

  // Hue stays below a full turn and saturation within percent range.
  `RHC_ASSERT_IMPL(a_hue_range, clk, rst_n, out_valid, hue < HUE_LIM, "hue out of range")
  `RHC_ASSERT_IMPL(a_sat_range, clk, rst_n, out_valid, saturation <= SAT_MAX, "saturation over 100")

  // A stalled result stays offered and unchanged.
  `RHC_ASSERT_NEXT(a_hold_valid, clk, rst_n, stalled, out_valid, "result dropped while stalled")
  `RHC_ASSERT_NEXT(a_hold_data, clk, rst_n, stalled, $stable(res_word), "result changed while stalled")

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .hue        (out_chan.hue),
  .saturation (out_chan.saturation),
  .brightness (out_chan.brightness),
  .channel_max(out_chan.channel_max),
  .channel_min(out_chan.channel_min)
);

`default_nettype wire
